/* hw/rtl/bksi_pkg.sv */
package bksi_pkg;

    localparam int BUCKET_BITS = 10;
    localparam int SLOTS       = 8;

    localparam int NUM_BUCKETS = 2 ** BUCKET_BITS;
    localparam int NUM_ENTRIES = NUM_BUCKETS * SLOTS;
    localparam int ENTRY_W     = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
    localparam int FILL_W      = $clog2(SLOTS + 1);

    // bucket index comes from bits 57:48 of key_high (within key bytes 0 and 1)
    localparam int BUCKET_LSB  = 48;

    typedef logic [BUCKET_BITS-1:0] t_bucket;
    typedef logic [ENTRY_W-1:0]     t_entry;
    typedef logic [FILL_W-1:0]      t_fill;

    typedef struct packed {
        logic [63:0] high;
        logic [63:0] mid;
        logic [31:0] low;
    } t_key;

    typedef struct packed {
        logic   rd_en;
        t_entry rd_addr;
        logic   wr_en;
        t_entry wr_addr;
    } t_store_req;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

endpackage

/* hw/rtl/bksi_in_if.sv */
interface bksi_in_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [63:0] key_high;
    logic [63:0] key_mid;
    logic [31:0] key_low;

    modport source (output valid, output action, output key_high, output key_mid,
                    output key_low, input ready);
    modport sink   (input valid, input action, input key_high, input key_mid,
                    input key_low, output ready);
endinterface

/* hw/rtl/bksi_out_if.sv */
interface bksi_out_if;
    logic valid;
    logic ready;
    logic found;
    logic status;

    modport source (output valid, output found, output status, input ready);
    modport sink   (input valid, input found, input status, output ready);
endinterface

/* hw/rtl/bucketed_key_set_insert_lookup.sv */
// Set of 160-bit keys in 2^BUCKET_BITS buckets of SLOTS slots. Each input
// transfer (lookup or add) yields one result: found and status. An item scans
// its bucket one stored key per cycle through a single read port of the key
// memory and one 160-bit comparator. A scan stops at the first hit or after the
// bucket's filled slots; its result then waits until the output register is
// free, and a new item is accepted while the previous result still waits on
// the output. After reset the bucket fill counts are cleared one per cycle, and
// the input is not ready until the clear pass over all buckets is done.
module bucketed_key_set_insert_lookup (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bksi_in_if.sink     i_in,
    bksi_out_if.source  o_out
);
    import bksi_pkg::*;

    t_state     r_state, n_state;
    t_bucket    r_clr, n_clr;
    t_fill      r_slot, n_slot;
    logic       r_cmp_vld, n_cmp_vld;
    logic       r_found, n_found;
    logic       r_status, n_status;
    logic       r_out_valid, n_out_valid;
    logic       r_out_found, r_out_status;

    logic       r_action;
    t_key       r_key;
    t_bucket    r_bucket;
    t_entry     r_base;
    t_fill      r_fill_rd;

    t_fill      r_fill_mem [NUM_BUCKETS];

    logic       in_ready;
    logic       in_accept;
    t_bucket    in_bucket;
    logic       issue;
    logic       key_match;
    logic       load_out;
    t_store_req st_req;
    t_key       rd_key;
    logic       fill_wr_en;
    t_bucket    fill_wr_addr;
    t_fill      fill_wr_data;

    assign in_accept = i_in.valid && in_ready;
    assign in_bucket = i_in.key_high[BUCKET_LSB +: BUCKET_BITS];
    assign issue     = r_slot < r_fill_rd;
    assign key_match = r_cmp_vld && (rd_key == r_key);

    always_comb begin
        n_state      = r_state;
        n_clr        = r_clr;
        n_slot       = r_slot;
        n_cmp_vld    = 1'b0;
        n_found      = r_found;
        n_status     = r_status;
        n_out_valid  = r_out_valid && !o_out.ready;
        load_out     = 1'b0;
        in_ready     = 1'b0;
        st_req       = '0;
        fill_wr_en   = 1'b0;
        fill_wr_addr = r_bucket;
        fill_wr_data = r_fill_rd + t_fill'(1);
        case (r_state)
            S_CLEAR: begin
                fill_wr_en   = 1'b1;
                fill_wr_addr = r_clr;
                fill_wr_data = '0;
                n_clr        = r_clr + t_bucket'(1);
                if (r_clr == '1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                in_ready = 1'b1;
                if (i_in.valid) begin
                    n_slot  = '0;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (key_match) begin
                    n_found  = 1'b1;
                    n_status = 1'b0;
                    n_state  = S_DONE;
                end else if (issue) begin
                    // read the next filled slot, compare it in the following cycle
                    st_req.rd_en   = 1'b1;
                    st_req.rd_addr = r_base + t_entry'(r_slot);
                    n_slot         = r_slot + t_fill'(1);
                    n_cmp_vld      = 1'b1;
                end else begin
                    n_found  = 1'b0;
                    n_status = 1'b0;
                    if (r_action) begin
                        if (r_fill_rd < t_fill'(SLOTS)) begin
                            st_req.wr_en   = 1'b1;
                            st_req.wr_addr = r_base + t_entry'(r_fill_rd);
                            fill_wr_en     = 1'b1;
                        end else begin
                            n_status = 1'b1;
                        end
                    end
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid = 1'b1;
                    load_out    = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_cmp_vld   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_cmp_vld   <= n_cmp_vld;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot   <= n_slot;
        r_found  <= n_found;
        r_status <= n_status;
        if (in_accept) begin
            r_action <= i_in.action;
            r_key    <= '{high: i_in.key_high, mid: i_in.key_mid, low: i_in.key_low};
            r_bucket <= in_bucket;
            r_base   <= t_entry'(in_bucket) * t_entry'(SLOTS);
        end
        if (load_out) begin
            r_out_found  <= r_found;
            r_out_status <= r_status;
        end
    end

    // bucket fill counts, read on the input transfer
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_fill_rd <= r_fill_mem[in_bucket];
        end
        if (fill_wr_en) begin
            r_fill_mem[fill_wr_addr] <= fill_wr_data;
        end
    end

    bksi_key_store u_key_store (
        .i_clk    (i_clk),
        .i_req    (st_req),
        .i_wr_key (r_key),
        .o_rd_key (rd_key)
    );

    assign i_in.ready   = in_ready;
    assign o_out.valid  = r_out_valid;
    assign o_out.found  = r_out_found;
    assign o_out.status = r_out_status;

    a_wr_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        st_req.wr_en |-> (r_fill_rd < t_fill'(SLOTS)))
        else $error("slot write into a full bucket");

    a_rd_wr_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        st_req.rd_en |-> (r_state == S_SCAN) && !st_req.wr_en)
        else $error("key read outside scan or together with a write");

    a_slot_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_slot <= r_fill_rd))
        else $error("scan slot past bucket fill");

    a_result_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.status) |-> !o_out.found)
        else $error("full status reported on a found key");

    a_clear_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(r_state == S_CLEAR) && (r_state == S_IDLE)) |-> ($past(r_clr) == '1))
        else $error("fill clear pass ended early");

endmodule

/* hw/rtl/bksi_key_store.sv */
module bksi_key_store (
    input  logic                i_clk,
    input  bksi_pkg::t_store_req i_req,
    input  bksi_pkg::t_key      i_wr_key,
    output bksi_pkg::t_key      o_rd_key
);
    import bksi_pkg::*;

    t_key r_mem [NUM_ENTRIES];
    t_key r_rd_key;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_wr_key;
        end
        if (i_req.rd_en) begin
            r_rd_key <= r_mem[i_req.rd_addr];
        end
    end

    assign o_rd_key = r_rd_key;

endmodule

/* sim/bucketed_key_set_insert_lookup_tb.sv */
`timescale 1ns / 100ps

module bucketed_key_set_insert_lookup_tb;
    import bksi_pkg::*;

    localparam logic ACT_LOOKUP  = 1'b0;
    localparam logic ACT_ADD     = 1'b1;
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    localparam int RANDOM_ITEMS = 1950;
    localparam int IDLE_LIMIT   = 4000;
    localparam int TAIL_CYCLES  = 40;
    localparam int NUM_HOT      = 16;
    localparam int POOL_MAX     = 256;

    typedef struct packed {
        logic action;
        t_key key;
    } key_request_t;

    typedef struct packed {
        logic found;
        logic status;
    } set_result_t;

    logic i_clk;
    logic i_rst_n;

    bksi_in_if  in_if ();
    bksi_out_if out_if ();

    bucketed_key_set_insert_lookup dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // shadow copy of the set
    t_key set_keys [NUM_ENTRIES];
    int   set_fill [NUM_BUCKETS];

    key_request_t pending_requests [$];
    set_result_t  expected_results [$];
    t_key         key_pool [$];

    key_request_t on_bus;
    int burst_left;
    int gap_left;
    int stall_mode;
    int stall_left;
    int stall_cycle;
    int idle_cycles;
    int errors;
    int n_lookups;
    int n_adds;
    int n_found;
    int n_full;
    int n_results;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic set_result_t lookup_or_insert(key_request_t req);
        t_bucket     b;
        int          base;
        set_result_t res;
        b = req.key.high[BUCKET_LSB +: BUCKET_BITS];
        base = int'(b) * SLOTS;
        res.found = 1'b0;
        res.status = STATUS_OK;
        for (int s = 0; s < set_fill[b]; s++) begin
            if (set_keys[base + s] == req.key) res.found = 1'b1;
        end
        if (req.action == ACT_ADD) n_adds++;
        else n_lookups++;
        if (res.found) n_found++;
        if (req.action == ACT_ADD && !res.found) begin
            if (set_fill[b] >= SLOTS) begin
                res.status = STATUS_FULL;
                n_full++;
            end else begin
                set_keys[base + set_fill[b]] = req.key;
                set_fill[b]++;
            end
        end
        return res;
    endfunction

    function automatic t_key rand_key_in(t_bucket b);
        t_key k;
        k.high = {$urandom, $urandom};
        k.mid  = {$urandom, $urandom};
        k.low  = $urandom;
        k.high[BUCKET_LSB +: BUCKET_BITS] = b;
        return k;
    endfunction

    task automatic queue_item(logic action, t_key key);
        key_request_t req;
        req.action = action;
        req.key = key;
        pending_requests.push_back(req);
    endtask

    task automatic remember_key(t_key key);
        if (key_pool.size() < POOL_MAX) key_pool.push_back(key);
        else key_pool[$urandom_range(0, POOL_MAX - 1)] = key;
    endtask

    task automatic flag_error(string what);
        if (errors < 20) $display("[%0t] mismatch: %s", $realtime, what);
        errors++;
    endtask

    // sampled away from the rising edge so the sender's updates have settled
    task automatic wait_drained();
        while (pending_requests.size() != 0 || in_if.valid || expected_results.size() != 0)
            @(negedge i_clk);
    endtask

    // sender: bursts of transfers with random gaps in between
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
            burst_left = 0;
            gap_left = 0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                expected_results.push_back(lookup_or_insert(on_bus));
            end
            if (in_if.valid && !in_if.ready) begin
                // hold until the transfer happens
            end else if (gap_left > 0) begin
                gap_left--;
                in_if.valid <= 1'b0;
            end else if (pending_requests.size() > 0) begin
                on_bus = pending_requests.pop_front();
                in_if.valid    <= 1'b1;
                in_if.action   <= on_bus.action;
                in_if.key_high <= on_bus.key.high;
                in_if.key_mid  <= on_bus.key.mid;
                in_if.key_low  <= on_bus.key.low;
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 60);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                end
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    // receiver: checks each result transfer and stalls on its own pattern
    always @(posedge i_clk) begin
        set_result_t want;
        logic        rdy;
        if (i_rst_n) begin
            if (out_if.valid && out_if.ready) begin
                n_results++;
                if (expected_results.size() == 0) begin
                    flag_error("result transfer with no expectation pending");
                end else begin
                    want = expected_results.pop_front();
                    if (out_if.found !== want.found)
                        flag_error($sformatf("result %0d: found %b, expected %b",
                                             n_results, out_if.found, want.found));
                    if (out_if.status !== want.status)
                        flag_error($sformatf("result %0d: status %b, expected %b",
                                             n_results, out_if.status, want.status));
                end
            end
        end
        stall_cycle++;
        if (stall_cycle % 256 == 0) stall_mode = $urandom_range(0, 3);
        if (stall_left > 0) begin
            stall_left--;
            rdy = 1'b0;
        end else begin
            case (stall_mode)
                0: rdy = 1'b1;
                1: rdy = 1'($urandom_range(0, 1));
                2: rdy = (stall_cycle % 5) != 0;
                default: begin
                    rdy = 1'b1;
                    if ($urandom_range(0, 15) == 0) stall_left = $urandom_range(5, 20);
                end
            endcase
        end
        out_if.ready <= rdy;
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: %0d cycles without a transfer", idle_cycles);
            $display("== FAIL ==");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        t_key        zero_key;
        t_key        ones_key;
        t_key        k;
        t_key        slot_last;
        t_bucket     hot_buckets [NUM_HOT];
        logic [159:0] kv;
        int          r;

        i_clk = 1'b0;
        i_rst_n = 1'b0;
        in_if.valid = 1'b0;
        in_if.action = ACT_LOOKUP;
        in_if.key_high = '0;
        in_if.key_mid = '0;
        in_if.key_low = '0;
        out_if.ready = 1'b0;
        errors = 0;
        idle_cycles = 0;
        stall_mode = 0;
        stall_left = 0;
        stall_cycle = 0;
        n_lookups = 0;
        n_adds = 0;
        n_found = 0;
        n_full = 0;
        n_results = 0;
        for (int i = 0; i < NUM_BUCKETS; i++) set_fill[i] = 0;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty set, both extremes of the key, a bucket filled to the top
        zero_key = '0;
        ones_key = '1;
        queue_item(ACT_LOOKUP, zero_key);
        queue_item(ACT_ADD, zero_key);
        queue_item(ACT_LOOKUP, zero_key);
        queue_item(ACT_ADD, zero_key);
        queue_item(ACT_ADD, ones_key);
        queue_item(ACT_LOOKUP, ones_key);
        slot_last = zero_key;
        for (int s = 1; s < SLOTS; s++) begin
            k = zero_key;
            k.low = s;
            if (s == 2) k.mid[63] = 1'b1;
            if (s == SLOTS - 1) k.high[63] = 1'b1;
            queue_item(ACT_ADD, k);
            slot_last = k;
        end
        k = zero_key;
        k.low = 32'hffff_ffff;
        queue_item(ACT_ADD, k);            // bucket is already full, add refused
        queue_item(ACT_ADD, slot_last);    // present in a full bucket
        queue_item(ACT_LOOKUP, k);
        queue_item(ACT_LOOKUP, slot_last);
        k = ones_key;
        k.low[0] = 1'b0;
        queue_item(ACT_LOOKUP, k);
        k = ones_key;
        k.high[63] = 1'b0;                 // same bucket, differs above the index
        queue_item(ACT_LOOKUP, k);
        k = ones_key;
        k.mid[0] = 1'b0;
        queue_item(ACT_ADD, k);
        queue_item(ACT_LOOKUP, k);
        remember_key(zero_key);
        remember_key(ones_key);
        remember_key(slot_last);
        remember_key(k);
        wait_drained();

        hot_buckets[0] = '0;
        hot_buckets[1] = '1;
        for (int i = 2; i < NUM_HOT; i++) hot_buckets[i] = t_bucket'($urandom);

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            r = $urandom_range(0, 99);
            if (r < 45) begin
                k = key_pool[$urandom_range(0, key_pool.size() - 1)];
                if ($urandom_range(0, 3) == 0) begin
                    kv = k;
                    kv[$urandom_range(0, 159)] ^= 1'b1;
                    k = kv;
                end
            end else if (r < 85) begin
                k = rand_key_in(hot_buckets[$urandom_range(0, NUM_HOT - 1)]);
                remember_key(k);
            end else begin
                k = rand_key_in(t_bucket'($urandom));
                kv = k;
                kv[159 -: 16] = 16'($urandom);
                k = kv;
                remember_key(k);
            end
            queue_item(($urandom_range(0, 99) < 55) ? ACT_ADD : ACT_LOOKUP, k);
            // hold off the sender once until every result is back
            if (i == RANDOM_ITEMS / 2) wait_drained();
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (expected_results.size() != 0)
            flag_error($sformatf("%0d results never arrived", expected_results.size()));

        $display("covered %0d lookups and %0d adds: %0d hits, %0d refused on a full bucket",
                 n_lookups, n_adds, n_found, n_full);
        $display("%0d results checked, %0d mismatches", n_results, errors);
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
